// ===== hdl/disc_mesh_tessellator_defines.svh =====
// ----------------------------------------------------------------------------
// disc_mesh_tessellator_defines.svh
// Assertion macros of the tessellator RTL.
// ----------------------------------------------------------------------------
`ifndef DISC_MESH_TESSELLATOR_DEFINES_SVH
`define DISC_MESH_TESSELLATOR_DEFINES_SVH
`ifndef SYNTHESIS
// implication check, disabled in reset
`define DMT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// condition that must never hold
`define DMT_ASSERT_NEVER(lbl, clk, rst, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`else
`define DMT_ASSERT_IMPL(lbl, clk, rst, ante, cons, msg)
`define DMT_ASSERT_NEVER(lbl, clk, rst, cond, msg)
`endif
`endif

// ===== hdl/dmt_pkg.sv =====
// ----------------------------------------------------------------------------
// dmt_pkg
// Types, constants and helpers of the disc mesh tessellator.
// ----------------------------------------------------------------------------
package dmt_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int CNT_W    = 9;   // holds counts up to 256
  localparam int IDX_W    = 18;
  localparam int VTOT_W   = 19;

  localparam logic [1:0] CFG_COLUMN_COUNT = 2'd0;
  localparam logic [1:0] CFG_ROW_COUNT    = 2'd1;
  localparam logic [1:0] CFG_SPLIT_MODE   = 2'd2;
  localparam logic [1:0] CFG_DISC_RADIUS  = 2'd3;

  localparam logic KIND_VERTEX   = 1'b0;
  localparam logic KIND_TRIANGLE = 1'b1;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] vcol;
    logic [CNT_W-1:0] vrow;
    logic             load_vertex;
    logic             load_tri;
    logic [IDX_W-1:0] corner_one;
    logic [IDX_W-1:0] corner_two;
    logic [IDX_W-1:0] corner_three;
    logic             run_end;
    logic             mesh_done;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic vdone;
    logic out_free;
  } status_t;

  // 0 acts as 1, above the limit acts as the limit
  function automatic logic [CNT_W-1:0] used_count(input logic [CNT_W-1:0] c,
                                                  input logic [CNT_W-1:0] lim);
    logic [CNT_W-1:0] r;
    r = c;
    if (r == '0) r = CNT_W'(1);
    if (r > lim) r = lim;
    return r;
  endfunction

  // CORDIC arctangents in 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [3:0] i);
    logic [31:0] a;
    unique case (i)
      4'd0:  a = 32'd536870912;
      4'd1:  a = 32'd316933406;
      4'd2:  a = 32'd167458907;
      4'd3:  a = 32'd85004756;
      4'd4:  a = 32'd42667331;
      4'd5:  a = 32'd21354465;
      4'd6:  a = 32'd10679838;
      4'd7:  a = 32'd5340245;
      4'd8:  a = 32'd2670163;
      4'd9:  a = 32'd1335087;
      4'd10: a = 32'd667544;
      4'd11: a = 32'd333772;
      4'd12: a = 32'd166886;
      4'd13: a = 32'd83443;
      4'd14: a = 32'd41722;
      4'd15: a = 32'd20861;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== hdl/dmt_stream_if.sv =====
// ----------------------------------------------------------------------------
// dmt_stream_if
// Valid/ready channels of the tessellator: tick input and record output.
// ----------------------------------------------------------------------------
interface dmt_in_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface dmt_out_if;
  logic               valid;
  logic               ready;
  logic               record_kind;
  logic signed [17:0] pos_x;
  logic signed [17:0] pos_y;
  logic        [16:0] tex_u;
  logic        [16:0] tex_v;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic        [17:0] corner_one;
  logic        [17:0] corner_two;
  logic        [17:0] corner_three;
  logic               run_end;
  logic               mesh_done;
  modport source (output valid, output record_kind, output pos_x, output pos_y,
                  output tex_u, output tex_v, output normal_x, output normal_y,
                  output corner_one, output corner_two, output corner_three,
                  output run_end, output mesh_done, input ready);
  modport sink   (input valid, input record_kind, input pos_x, input pos_y,
                  input tex_u, input tex_v, input normal_x, input normal_y,
                  input corner_one, input corner_two, input corner_three,
                  input run_end, input mesh_done, output ready);
endinterface

// ===== hdl/dmt_datapath.sv =====
// ----------------------------------------------------------------------------
// dmt_datapath
// Vertex engine (bit-serial divider, CORDIC, scaling) and output register.
// ----------------------------------------------------------------------------
module dmt_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dmt_pkg::CNT_W-1:0]  cols,
  input  logic [dmt_pkg::CNT_W-1:0]  rows,
  input  logic [15:0]                disc_radius,
  input  dmt_pkg::cmd_t              cmd,
  output dmt_pkg::status_t           status,
  dmt_out_if.source                  out_ch
);

  localparam logic [3:0] P_IDLE = 4'd0, P_DIVU = 4'd1, P_DIVV = 4'd2, P_CORD = 4'd3,
                         P_TRIG = 4'd4, P_RAD = 4'd5, P_POSX = 4'd6, P_POSY = 4'd7,
                         P_DONE = 4'd8;
  localparam int DIV_N = 25;

  logic [3:0]         phase;
  logic [4:0]         cnt;
  logic [8:0]         vrow_l;
  logic [8:0]         rem;
  logic [DIV_N-1:0]   dq;
  logic [16:0]        u_q, v_q;
  logic signed [33:0] cx, cy, cz;
  logic signed [15:0] sn, ny;
  logic [16:0]        rad;
  logic signed [17:0] px, py;

  logic [9:0]         trial;
  logic [8:0]         rem_nx;
  logic [DIV_N-1:0]   dq_nx;
  logic signed [33:0] dx, dy, at;
  logic signed [17:0] s_r, c_r;
  logic signed [15:0] s_c, c_c, sn_m, cs_m;
  logic [33:0]        rprod;
  logic signed [33:0] pprod;
  logic               out_free;

  function automatic logic signed [15:0] clamp14(input logic signed [17:0] v);
    logic signed [15:0] r;
    if (v > 18'sd16384) r = 16'sd16384;
    else if (v < -18'sd16384) r = -16'sd16384;
    else r = v[15:0];
    return r;
  endfunction

  always_comb begin
    trial  = {rem, dq[DIV_N-1]} - {1'b0, cols};
    if (!trial[9]) begin
      rem_nx = trial[8:0];
      dq_nx  = {dq[DIV_N-2:0], 1'b1};
    end else begin
      rem_nx = {rem[7:0], dq[DIV_N-1]};
      dq_nx  = {dq[DIV_N-2:0], 1'b0};
    end
    dx = cy >>> cnt[3:0];
    dy = cx >>> cnt[3:0];
    at = $signed({2'b00, dmt_pkg::atan_turn(cnt[3:0])});
    s_r = 18'((cy + 34'sd32768) >>> 16);
    c_r = 18'((cx + 34'sd32768) >>> 16);
    s_c = clamp14(s_r);
    c_c = clamp14(c_r);
    unique case (u_q[15:14])
      2'd0:    begin sn_m = s_c;  cs_m = c_c;  end
      2'd1:    begin sn_m = c_c;  cs_m = -s_c; end
      2'd2:    begin sn_m = -s_c; cs_m = -c_c; end
      default: begin sn_m = -c_c; cs_m = s_c;  end
    endcase
    rprod = 34'(v_q) * 34'(disc_radius) + 34'd32768;
    pprod = ((phase == P_POSX) ? sn : ny) * $signed({1'b0, rad}) + 34'sd8192;
  end

  // quotient also uses rows as divisor in the second pass
  logic [9:0] trial_v;
  logic [8:0] rem_nx_v;
  logic [DIV_N-1:0] dq_nx_v;
  always_comb begin
    trial_v = {rem, dq[DIV_N-1]} - {1'b0, rows};
    if (!trial_v[9]) begin
      rem_nx_v = trial_v[8:0];
      dq_nx_v  = {dq[DIV_N-2:0], 1'b1};
    end else begin
      rem_nx_v = {rem[7:0], dq[DIV_N-1]};
      dq_nx_v  = {dq[DIV_N-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= P_IDLE;
      cnt   <= '0;
    end else begin
      unique case (phase)
        P_IDLE: begin
          if (cmd.start) begin
            vrow_l <= cmd.vrow;
            dq     <= {cmd.vcol, 16'd0} + DIV_N'(cols >> 1);
            rem    <= '0;
            cnt    <= '0;
            phase  <= P_DIVU;
          end
        end
        P_DIVU: begin
          if (cnt == 5'(DIV_N - 1)) begin
            u_q   <= dq_nx[16:0];
            dq    <= {vrow_l, 16'd0} + DIV_N'(rows >> 1);
            rem   <= '0;
            cnt   <= '0;
            phase <= P_DIVV;
          end else begin
            rem <= rem_nx;
            dq  <= dq_nx;
            cnt <= cnt + 5'd1;
          end
        end
        P_DIVV: begin
          if (cnt == 5'(DIV_N - 1)) begin
            v_q   <= dq_nx_v[16:0];
            cx    <= 34'sd652032874;
            cy    <= '0;
            cz    <= $signed({4'd0, u_q[13:0], 16'd0});
            cnt   <= '0;
            phase <= P_CORD;
          end else begin
            rem <= rem_nx_v;
            dq  <= dq_nx_v;
            cnt <= cnt + 5'd1;
          end
        end
        P_CORD: begin
          if (!cz[33]) begin
            cx <= cx - dx; cy <= cy + dy; cz <= cz - at;
          end else begin
            cx <= cx + dx; cy <= cy - dy; cz <= cz + at;
          end
          cnt <= cnt + 5'd1;
          if (cnt == 5'd15) phase <= P_TRIG;
        end
        P_TRIG: begin
          sn    <= sn_m;
          ny    <= -cs_m;
          phase <= P_RAD;
        end
        P_RAD: begin
          rad   <= rprod[32:16];
          phase <= P_POSX;
        end
        P_POSX: begin
          px    <= pprod[31:14];
          phase <= P_POSY;
        end
        P_POSY: begin
          py    <= pprod[31:14];
          phase <= P_DONE;
        end
        P_DONE: begin
          if (cmd.load_vertex) phase <= P_IDLE;
        end
        default: phase <= P_IDLE;
      endcase
    end
  end

  // output register
  assign out_free = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (cmd.load_vertex || cmd.load_tri) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_vertex) begin
      out_ch.record_kind  <= dmt_pkg::KIND_VERTEX;
      out_ch.pos_x        <= px;
      out_ch.pos_y        <= py;
      out_ch.tex_u        <= u_q;
      out_ch.tex_v        <= v_q;
      out_ch.normal_x     <= sn;
      out_ch.normal_y     <= ny;
      out_ch.corner_one   <= '0;
      out_ch.corner_two   <= '0;
      out_ch.corner_three <= '0;
      out_ch.run_end      <= cmd.run_end;
      out_ch.mesh_done    <= cmd.mesh_done;
    end else if (cmd.load_tri) begin
      out_ch.record_kind  <= dmt_pkg::KIND_TRIANGLE;
      out_ch.pos_x        <= '0;
      out_ch.pos_y        <= '0;
      out_ch.tex_u        <= '0;
      out_ch.tex_v        <= '0;
      out_ch.normal_x     <= '0;
      out_ch.normal_y     <= '0;
      out_ch.corner_one   <= cmd.corner_one;
      out_ch.corner_two   <= cmd.corner_two;
      out_ch.corner_three <= cmd.corner_three;
      out_ch.run_end      <= cmd.run_end;
      out_ch.mesh_done    <= cmd.mesh_done;
    end
  end

  assign status.busy     = (phase != P_IDLE);
  assign status.vdone    = (phase == P_DONE);
  assign status.out_free = out_free;

endmodule

// ===== hdl/dmt_ctrl.sv =====
// ----------------------------------------------------------------------------
// dmt_ctrl
// Cell sequencer: grid position, vertex sharing and record order.
// ----------------------------------------------------------------------------
module dmt_ctrl (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [dmt_pkg::CNT_W-1:0]  cols,
  input  logic [dmt_pkg::CNT_W-1:0]  rows,
  input  logic                       split_mode,
  input  dmt_pkg::status_t           status,
  output dmt_pkg::cmd_t              cmd,
  dmt_in_if.sink                     in_ch
);

  localparam logic [2:0] S_IDLE = 3'd0, S_SLOT = 3'd1, S_VWAIT = 3'd2,
                         S_TRI1 = 3'd3, S_TRI2 = 3'd4;
  localparam int W  = dmt_pkg::CNT_W;
  localparam int IW = dmt_pkg::IDX_W;

  logic [2:0]                    state, state_next;
  logic [W-1:0]                  cur_col, cur_row, wcol, wrow;
  logic [dmt_pkg::VTOT_W-1:0]    vertex_total;
  logic                          finished, wsplit, wlast, wdone;
  logic [IW-1:0]                 row_first_a, row_first_b, prev_c_index, prev_d_index;
  logic [1:0]                    slot;
  logic [IW-1:0]                 corner [4];

  logic [W-1:0]  cc, cr, cc2, cr2, nc, cr_inc;
  logic          fin, run, need, commit;
  logic [IW-1:0] commit_idx, store_idx;

  always_comb begin
    cc  = in_ch.restart ? '0 : cur_col;
    cr  = in_ch.restart ? '0 : cur_row;
    fin = in_ch.restart ? 1'b0 : finished;
    if (cc >= cols) begin
      cc2 = '0;
      cr2 = cr + W'(1);
    end else begin
      cc2 = cc;
      cr2 = cr;
    end
    run    = !fin && (cr2 < rows);
    nc     = cc2 + W'(1);
    cr_inc = cr2 + W'(1);

    unique case (slot)
      2'd0:    need = wsplit || (wcol == '0 && wrow == '0);
      2'd1:    need = wsplit || (wcol == '0);
      default: need = wsplit || !wlast;
    endcase
    unique case (slot)
      2'd0:    store_idx = (wrow == '0) ? row_first_a : prev_d_index;
      2'd1:    store_idx = prev_c_index;
      2'd2:    store_idx = row_first_b;
      default: store_idx = row_first_a;
    endcase

    cmd        = '0;
    cmd.vcol   = (slot[1]) ? wcol + W'(1) : wcol;
    cmd.vrow   = (slot == 2'd1 || slot == 2'd2) ? wrow + W'(1) : wrow;
    cmd.mesh_done = wdone;
    commit     = 1'b0;
    commit_idx = store_idx;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_ch.valid && run) state_next = S_SLOT;
      end
      S_SLOT: begin
        if (need) begin
          cmd.start  = 1'b1;
          state_next = S_VWAIT;
        end else begin
          commit = 1'b1;
          if (slot == 2'd3) state_next = S_TRI1;
        end
      end
      S_VWAIT: begin
        if (status.vdone && status.out_free) begin
          cmd.load_vertex = 1'b1;
          commit     = 1'b1;
          commit_idx = vertex_total[IW-1:0];
          state_next = (slot == 2'd3) ? S_TRI1 : S_SLOT;
        end
      end
      S_TRI1: begin
        if (status.out_free) begin
          cmd.load_tri     = 1'b1;
          cmd.corner_one   = corner[0];
          cmd.corner_two   = corner[1];
          cmd.corner_three = corner[2];
          cmd.run_end      = !(wrow != '0 || wsplit);
          state_next       = cmd.run_end ? S_IDLE : S_TRI2;
        end
      end
      S_TRI2: begin
        if (status.out_free) begin
          cmd.load_tri     = 1'b1;
          cmd.corner_one   = corner[2];
          cmd.corner_two   = corner[3];
          cmd.corner_three = corner[0];
          cmd.run_end      = 1'b1;
          state_next       = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      cur_col      <= '0;
      cur_row      <= '0;
      vertex_total <= '0;
      finished     <= 1'b0;
      slot         <= '0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && in_ch.valid) begin
        if (in_ch.restart) vertex_total <= '0;
        slot   <= '0;
        wcol   <= cc2;
        wrow   <= cr2;
        wsplit <= split_mode;
        wlast  <= (nc == cols);
        wdone  <= (nc >= cols) && (cr_inc >= rows);
        if (fin) begin
          // finished mesh: position is kept
          finished <= 1'b1;
        end else if (!run) begin
          finished <= 1'b1;
          cur_col  <= cc2;
          cur_row  <= cr2;
        end else if (nc >= cols) begin
          cur_col  <= '0;
          cur_row  <= cr_inc;
          finished <= (cr_inc >= rows);
        end else begin
          cur_col  <= nc;
          cur_row  <= cr2;
          finished <= 1'b0;
        end
      end
      if (commit) begin
        slot <= slot + 2'd1;
        if (cmd.load_vertex) vertex_total <= vertex_total + dmt_pkg::VTOT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      corner[slot] <= commit_idx;
      if (slot == 2'd0 && wcol == '0) row_first_a <= commit_idx;
      if (slot == 2'd1 && wcol == '0) row_first_b <= commit_idx;
      if (slot == 2'd2) prev_c_index <= commit_idx;
      if (slot == 2'd3) prev_d_index <= commit_idx;
    end
  end

endmodule

// ===== hdl/disc_mesh_tessellator.sv =====
// ----------------------------------------------------------------------------
// disc_mesh_tessellator
// Polar-grid triangle mesh generator for a flat disc.
// ----------------------------------------------------------------------------
// Each accepted tick processes one grid cell, row-major, and produces its new
// vertex records followed by one or two triangle records; a tick after the
// final cell produces nothing. One tick at a time is in flight. Every new
// vertex runs through one shared engine: two 25-step bit-serial divisions for
// u and v, a 16-step CORDIC, then four scaling steps. A cell needs 0 to 4 new
// vertices and reuses its other corners; output stalls lengthen a tick.
// ----------------------------------------------------------------------------
`include "disc_mesh_tessellator_defines.svh"

module disc_mesh_tessellator (
  input  logic        clk,
  input  logic        rst,
  input  logic        write_enable,
  input  logic [1:0]  reg_index,
  input  logic [15:0] write_data,
  dmt_in_if.sink      in_ch,
  dmt_out_if.source   out_ch
);

  logic [dmt_pkg::CNT_W-1:0] column_count, row_count, cols, rows;
  logic                      split_mode;
  logic [15:0]               disc_radius;
  dmt_pkg::cmd_t             cmd;
  dmt_pkg::status_t          status;

  // configuration registers; the user writes them only while idle (not enforced)
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= dmt_pkg::CNT_W'(16);
      row_count    <= dmt_pkg::CNT_W'(4);
      split_mode   <= 1'b0;
      disc_radius  <= 16'd256;
    end else if (write_enable) begin
      unique case (reg_index)
        dmt_pkg::CFG_COLUMN_COUNT: column_count <= write_data[dmt_pkg::CNT_W-1:0];
        dmt_pkg::CFG_ROW_COUNT:    row_count    <= write_data[dmt_pkg::CNT_W-1:0];
        dmt_pkg::CFG_SPLIT_MODE:   split_mode   <= write_data[0];
        default:                   disc_radius  <= write_data;
      endcase
    end
  end

  // clamp counts to the usable range
  assign cols = dmt_pkg::used_count(column_count, dmt_pkg::CNT_W'(dmt_pkg::MAX_COLS));
  assign rows = dmt_pkg::used_count(row_count, dmt_pkg::CNT_W'(dmt_pkg::MAX_ROWS));

  dmt_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cols       (cols),
    .rows       (rows),
    .split_mode (split_mode),
    .status     (status),
    .cmd        (cmd),
    .in_ch      (in_ch)
  );

  dmt_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cols        (cols),
    .rows        (rows),
    .disc_radius (disc_radius),
    .cmd         (cmd),
    .status      (status),
    .out_ch      (out_ch)
  );

  // input is taken only with the vertex engine at rest
  `DMT_ASSERT_IMPL(a_ready_idle, clk, rst, in_ch.ready, !status.busy, "ready while engine busy")
  // a vertex record is never the last of a tick
  `DMT_ASSERT_IMPL(a_vtx_not_end, clk, rst,
    out_ch.valid && out_ch.record_kind == dmt_pkg::KIND_VERTEX, !out_ch.run_end,
    "vertex record flagged as run end")
  // engine is started only when free
  `DMT_ASSERT_NEVER(a_start_busy, clk, rst, cmd.start && status.busy, "start while busy")

endmodule
